/* rtl/lzwenc_pkg.sv */
`default_nettype none

package lzwenc_pkg;

    // Dictionary geometry
    localparam int CODE_LIMIT   = 4096;
    localparam int SYMBOL_COUNT = 256;

    // Fixed field widths
    localparam int PIX_W  = 8;
    localparam int CODE_W = 12;
    localparam int BITS_W = 4;
    localparam int GEN_W  = 8;

    // Derived widths
    localparam int VAL_W      = $clog2(CODE_LIMIT + 1);
    localparam int PREFIX_W   = $clog2(CODE_LIMIT);
    localparam int DICT_DEPTH = CODE_LIMIT * SYMBOL_COUNT;
    localparam int DICT_AW    = PREFIX_W + PIX_W;

    // Code constants
    localparam logic [CODE_W-1:0] CLEAR_CODE  = CODE_W'(SYMBOL_COUNT);
    localparam logic [VAL_W-1:0]  FIRST_FREE  = VAL_W'(SYMBOL_COUNT + 2);
    localparam logic [VAL_W-1:0]  LIMIT_VAL   = VAL_W'(CODE_LIMIT);
    localparam logic [BITS_W-1:0] START_WIDTH = BITS_W'(PIX_W + 1);
    localparam logic [BITS_W-1:0] MAX_WIDTH   = BITS_W'(CODE_W);
    localparam logic [GEN_W-1:0]  GEN_START   = GEN_W'(1);

    // Queues
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
    localparam int MAX_PUSH = 3;
    localparam int PUSH_CW  = $clog2(MAX_PUSH + 1);

    // Back-end sequencer states
    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             first;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits;
        logic              eof;
    } t_word;

    typedef struct packed {
        logic [PUSH_CW-1:0]       count;
        t_word [MAX_PUSH-1:0]     word;
    } t_push;

    typedef struct packed {
        logic [GEN_W-1:0] tag;
        logic [VAL_W-1:0] val;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/lzwenc_ram.sv */
`default_nettype none

module lzwenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lzwenc_front.sv */
`default_nettype none

module lzwenc_front import lzwenc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_last_pixel,
    output logic                  o_item_valid,
    output t_item                 o_item,
    input  wire logic             i_item_pop
);

    t_item             r_q [FQ_DEPTH];
    logic [FQ_AW-1:0]  r_wptr, r_rptr;
    logic [FQ_CW-1:0]  r_count, n_count;
    logic              r_in_frame;
    logic              w_push;
    t_item             w_item;

    assign o_ready      = (r_count < FQ_CW'(FQ_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rptr];

    // Tag the first word of each frame here so the back end needs no frame state
    always_comb begin
        w_item.pixel = i_pixel;
        w_item.last  = i_last_pixel;
        w_item.first = !r_in_frame;
        n_count      = r_count + FQ_CW'(w_push) - FQ_CW'(i_item_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr     <= r_wptr + FQ_AW'(1);
                r_in_frame <= !i_last_pixel;
            end
            if (i_item_pop) begin
                r_rptr <= r_rptr + FQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/lzwenc_back.sv */
`default_nettype none

module lzwenc_back import lzwenc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_item_pop,
    input  wire logic  i_out_room,
    output t_push      o_push
);

    logic [1:0]          r_state, n_state;
    logic [DICT_AW-1:0]  r_sweep_addr, n_sweep_addr;
    logic [GEN_W-1:0]    r_gen, n_gen;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [VAL_W-1:0]    r_nfc, n_nfc;
    logic [BITS_W-1:0]   r_width, n_width;
    logic [PIX_W-1:0]    r_pix, n_pix;
    logic                r_last, n_last;

    logic [GEN_W-1:0]    w_gen_inc;
    logic                w_wrap;
    logic [VAL_W-1:0]    w_nfc_next, w_mask;
    logic                w_grow;
    logic                w_hit, w_full;

    logic                w_wr_en, w_rd_en;
    logic [DICT_AW-1:0]  w_wr_addr, w_rd_addr;
    t_entry              w_wr_data, w_rd_data;

    lzwenc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_gen_inc  = r_gen + GEN_W'(1);
    assign w_wrap     = (w_gen_inc == '0);
    assign w_nfc_next = (r_nfc < LIMIT_VAL) ? r_nfc + VAL_W'(1) : r_nfc;
    assign w_mask     = (VAL_W'(1) << r_width) - VAL_W'(1);
    assign w_grow     = (w_mask < w_nfc_next - VAL_W'(1)) && (w_nfc_next < LIMIT_VAL)
                        && (r_width < MAX_WIDTH);
    assign w_hit      = (w_rd_data.tag == r_gen);
    assign w_full     = (w_rd_data.val >= LIMIT_VAL);
    assign w_rd_addr  = {r_prefix, i_item.pixel};

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_gen        = r_gen;
        n_prefix     = r_prefix;
        n_nfc        = r_nfc;
        n_width      = r_width;
        n_pix        = r_pix;
        n_last       = r_last;
        o_item_pop   = 1'b0;
        o_push       = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = {r_prefix, r_pix};
        w_wr_data    = '0;
        w_rd_en      = 1'b0;

        case (r_state)
            ST_SWEEP: begin
                // Zero one tag a cycle
                w_wr_en   = 1'b1;
                w_wr_addr = r_sweep_addr;
                if (r_sweep_addr == DICT_AW'(DICT_DEPTH - 1)) begin
                    n_sweep_addr = '0;
                    n_state      = ST_LOOK;
                end else begin
                    n_sweep_addr = r_sweep_addr + DICT_AW'(1);
                end
            end

            ST_LOOK: begin
                if (i_item_valid && i_out_room) begin
                    o_item_pop = 1'b1;
                    if (i_item.first) begin
                        // Frame start: restart table, emit clear, and the pixel too if the frame ends here
                        n_gen                 = w_wrap ? GEN_START : w_gen_inc;
                        n_nfc                 = FIRST_FREE;
                        n_width               = START_WIDTH;
                        n_prefix              = PREFIX_W'(i_item.pixel);
                        o_push.word[0].code   = CLEAR_CODE;
                        o_push.word[0].bits   = START_WIDTH;
                        o_push.count          = PUSH_CW'(1);
                        if (i_item.last) begin
                            o_push.word[1].code = CODE_W'(i_item.pixel);
                            o_push.word[1].bits = START_WIDTH;
                            o_push.word[1].eof  = 1'b1;
                            o_push.count        = PUSH_CW'(2);
                        end
                        n_state = w_wrap ? ST_SWEEP : ST_LOOK;
                    end else begin
                        w_rd_en = 1'b1;
                        n_pix   = i_item.pixel;
                        n_last  = i_item.last;
                        n_state = ST_WAIT;
                    end
                end
            end

            ST_WAIT: begin
                n_state = ST_LOOK;
                if (w_hit && !w_full) begin
                    // Extend the current string
                    n_prefix = w_rd_data.val[PREFIX_W-1:0];
                    if (r_last) begin
                        o_push.word[0].code = CODE_W'(w_rd_data.val);
                        o_push.word[0].bits = r_width;
                        o_push.word[0].eof  = 1'b1;
                        o_push.count        = PUSH_CW'(1);
                    end
                end else begin
                    o_push.word[0].code = CODE_W'(r_prefix);
                    o_push.word[0].bits = r_width;
                    n_prefix            = PREFIX_W'(r_pix);
                    if (w_hit) begin
                        // Table full: emit clear at the old width, restart
                        o_push.word[1].code = CLEAR_CODE;
                        o_push.word[1].bits = r_width;
                        o_push.count        = PUSH_CW'(2);
                        n_gen               = w_wrap ? GEN_START : w_gen_inc;
                        n_nfc               = FIRST_FREE;
                        n_width             = START_WIDTH;
                        n_state             = w_wrap ? ST_SWEEP : ST_LOOK;
                        if (r_last) begin
                            o_push.word[2].code = CODE_W'(r_pix);
                            o_push.word[2].bits = START_WIDTH;
                            o_push.word[2].eof  = 1'b1;
                            o_push.count        = PUSH_CW'(3);
                        end
                    end else begin
                        // New entry under the next free code
                        w_wr_en       = 1'b1;
                        w_wr_data.tag = r_gen;
                        w_wr_data.val = r_nfc;
                        n_nfc         = w_nfc_next;
                        n_width       = w_grow ? r_width + BITS_W'(1) : r_width;
                        o_push.count  = PUSH_CW'(1);
                        if (r_last) begin
                            o_push.word[1].code = CODE_W'(r_pix);
                            o_push.word[1].bits = w_grow ? r_width + BITS_W'(1) : r_width;
                            o_push.word[1].eof  = 1'b1;
                            o_push.count        = PUSH_CW'(2);
                        end
                    end
                end
            end

            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_gen        <= GEN_START;
            r_prefix     <= '0;
            r_nfc        <= FIRST_FREE;
            r_width      <= START_WIDTH;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_gen        <= n_gen;
            r_prefix     <= n_prefix;
            r_nfc        <= n_nfc;
            r_width      <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

/* rtl/lzwenc_outq.sv */
`default_nettype none

module lzwenc_outq import lzwenc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_word      o_word
);

    t_word            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wptr, r_rptr;
    logic [OQ_CW-1:0] r_count, n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rptr];
    assign w_pop   = o_valid && i_ready;
    // Leave space for the largest burst one item can cause
    assign o_room  = (r_count <= OQ_CW'(OQ_DEPTH - MAX_PUSH));
    assign n_count = r_count + OQ_CW'(i_push.count) - OQ_CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            r_wptr  <= r_wptr + OQ_AW'(i_push.count);
            if (w_pop) begin
                r_rptr <= r_rptr + OQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (k < int'(i_push.count)) begin
                r_mem[r_wptr + OQ_AW'(k)] <= i_push.word[k];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/lzw_code_stream_encoder.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// pixel     in         i_valid / o_ready  i_pixel[7:0], i_last_pixel
// code      out        o_valid / i_ready  o_code[11:0], o_code_bits[3:0], o_end_of_frame
//
// Back end: a pixel that continues a frame passes ST_LOOK for the dictionary read and then
//   ST_WAIT to decide and write back; the next lookup address needs the prefix that this
//   decision returns. The first pixel of a frame is handled in ST_LOOK alone.
// Reset: synchronous, active low. After reset the dictionary tags are swept to zero
//   before the back end takes its first word; the input queue still takes two words
//   meanwhile. The same sweep runs after every 255th dictionary restart, when the
//   generation counter wraps.
// Stalls: a two-word input queue and a four-word output queue part the sides; the
//   back end takes a word only when the output queue has room for three codes.

module lzw_code_stream_encoder import lzwenc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [PIX_W-1:0]  i_pixel,
    input  wire logic              i_last_pixel,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CODE_W-1:0]      o_code,
    output logic [BITS_W-1:0]      o_code_bits,
    output logic                   o_end_of_frame
);

    logic  w_item_valid;
    t_item w_item;
    logic  w_item_pop;
    logic  w_out_room;
    t_push w_push;
    t_word w_word;

    // Front: accept pixels, mark frame starts, queue them
    lzwenc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    // Back: dictionary lookup, code emission, table restarts
    lzwenc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_out_room   (w_out_room),
        .o_push       (w_push)
    );

    // Output queue: hold up to three codes per pixel until taken
    lzwenc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_out_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (w_word)
    );

    assign o_code         = w_word.code;
    assign o_code_bits    = w_word.bits;
    assign o_end_of_frame = w_word.eof;

endmodule

`default_nettype wire

/* tb/tb_lzw_code_stream_encoder.sv */
`timescale 1ns / 1ps

import lzwenc_pkg::*;

class lzw_tracker;
    // Entries made since the last table restart, keyed by {prefix, pixel}
    logic [VAL_W-1:0]    code_of [logic [DICT_AW-1:0]];
    logic [PREFIX_W-1:0] prefix;
    logic [VAL_W-1:0]    next_free;
    logic [BITS_W-1:0]   width;
    bit                  in_frame;
    t_word               expected_codes [$];
    int                  fault_count;

    function new();
        prefix      = '0;
        next_free   = FIRST_FREE;
        width       = START_WIDTH;
        in_frame    = 1'b0;
        fault_count = 0;
    endfunction

    function void restart_table();
        code_of.delete();
        next_free = FIRST_FREE;
        width     = START_WIDTH;
    endfunction

    function void queue_code(logic [CODE_W-1:0] code, logic [BITS_W-1:0] bits, logic eof);
        t_word w;
        w.code = code;
        w.bits = bits;
        w.eof  = eof;
        expected_codes.push_back(w);
    endfunction

    function int pending();
        return expected_codes.size();
    endfunction

    function void add_pixel(logic [PIX_W-1:0] pix, logic last);
        logic [DICT_AW-1:0] key;
        logic [VAL_W-1:0]   val;
        bit                 hit;
        if (!in_frame) begin
            restart_table();
            queue_code(CLEAR_CODE, START_WIDTH, 1'b0);
            prefix   = PREFIX_W'(pix);
            in_frame = 1'b1;
        end else begin
            key = {prefix, pix};
            hit = code_of.exists(key);
            val = hit ? code_of[key] : '0;
            if (hit && val < LIMIT_VAL) begin
                prefix = val[PREFIX_W-1:0];
            end else begin
                queue_code(CODE_W'(prefix), width, 1'b0);
                if (hit) begin
                    queue_code(CLEAR_CODE, width, 1'b0);
                    restart_table();
                end else begin
                    code_of[key] = next_free;
                    if (next_free < LIMIT_VAL)
                        next_free = next_free + 1'b1;
                    if (((1 << width) - 1) < (int'(next_free) - 1) &&
                        next_free < LIMIT_VAL && width < MAX_WIDTH)
                        width = width + 1'b1;
                end
                prefix = PREFIX_W'(pix);
            end
        end
        if (last) begin
            queue_code(CODE_W'(prefix), width, 1'b1);
            in_frame = 1'b0;
        end
    endfunction

    function void check_code(logic [CODE_W-1:0] code, logic [BITS_W-1:0] bits, logic eof);
        t_word w;
        if (expected_codes.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("unexpected code word: code %0d bits %0d eof %0b", code, bits, eof);
            return;
        end
        w = expected_codes.pop_front();
        if (w.code !== code || w.bits !== bits || w.eof !== eof) begin
            fault_count++;
            if (fault_count <= 10)
                $display("code word mismatch (code/bits/eof): expected %0d/%0d/%0b, got %0d/%0d/%0b",
                         w.code, w.bits, w.eof, code, bits, eof);
        end
    endfunction
endclass

module tb_lzw_code_stream_encoder;

    // Allow for the tag sweep after reset on top of any normal stall
    localparam int WATCHDOG_LIMIT = 4 * DICT_DEPTH + 4096;
    localparam int RANDOM_PIXELS  = 250;
    localparam int HOLD_CYCLES    = 80;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [PIX_W-1:0]   i_pixel      = '0;
    logic               i_last_pixel = 1'b0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [CODE_W-1:0]  o_code;
    logic [BITS_W-1:0]  o_code_bits;
    logic               o_end_of_frame;

    lzw_tracker tracker;

    // Idling controls, set by the stimulus process, and the counters that the processes keep
    bit feeder_idle     = 1'b0;
    bit drain_idle      = 1'b0;
    bit drain_hold_req  = 1'b0;
    int random_sent     = 0;
    int stall_left      = 0;
    int quiet_cycles    = 0;

    lzw_code_stream_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .i_last_pixel   (i_last_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code         (o_code),
        .o_code_bits    (o_code_bits),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offer one pixel word, hold it until taken, then note it in the tracker.
    // Drop valid only when a gap follows; the next send raises it again.
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic last);
        i_valid      <= 1'b1;
        i_pixel      <= pix;
        i_last_pixel <= last;
        do @(posedge i_clk); while (!o_ready);
        tracker.add_pixel(pix, last);
        if (feeder_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // One frame of random pixels drawn from 0..top
    task automatic send_frame(int len, int top);
        for (int k = 0; k < len; k++)
            send_pixel(PIX_W'($urandom_range(0, top)), k == len - 1);
        random_sent += len;
    endtask

    // Main stimulus
    initial begin
        bit pressure_done;
        int len;
        int top;
        pressure_done = 1'b0;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-pixel frames at both extremes of the index
        feeder_idle = 1'b1;
        drain_idle  = 1'b1;
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        // Runs of one index and alternating pairs build strings that hit the table
        for (int k = 0; k < 6; k++)
            send_pixel(8'h00, k == 5);
        for (int k = 0; k < 6; k++)
            send_pixel(k[0] ? 8'h55 : 8'hAA, k == 5);
        for (int k = 0; k < 4; k++)
            send_pixel(k[0] ? 8'h00 : 8'hFF, k == 3);

        // Random frames of mixed length and alphabet
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent >= RANDOM_PIXELS - 60) begin
                feeder_idle = 1'b0;
                drain_idle  = 1'b0;
            end else begin
                feeder_idle = $urandom_range(0, 3) != 0;
                drain_idle  = $urandom_range(0, 3) != 0;
            end
            case ($urandom_range(0, 2))
                0:       top = 3;
                1:       top = 15;
                default: top = 255;
            endcase
            if (!pressure_done && random_sent >= 100) begin
                // Hold off the drain and keep offering so the block backs up
                feeder_idle    = 1'b0;
                drain_hold_req = 1'b1;
                send_frame(24, 3);
                pressure_done = 1'b1;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
                send_frame(len, top);
            end
        end
        i_valid <= 1'b0;

        // Drain, then give the block time to show any stray word
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.fault_count == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Code side: check each taken word, then pick ready for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                tracker.check_code(o_code, o_code_bits, o_end_of_frame);
            if (drain_hold_req) begin
                stall_left     = HOLD_CYCLES;
                drain_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left--;
            end else if (drain_idle && $urandom_range(0, 7) == 0) begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a word
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/lzwenc_pkg.sv
rtl/lzwenc_ram.sv
rtl/lzwenc_front.sv
rtl/lzwenc_back.sv
rtl/lzwenc_outq.sv
rtl/lzw_code_stream_encoder.sv
tb/tb_lzw_code_stream_encoder.sv
